>>> sv/epg_pkg.sv
`timescale 1ns / 1ps
// epg_pkg: shared types and codes for the ellipse point generator.
// Used by epg_alu and ellipse_point_generator; no dependencies.
package epg_pkg;

   // command codes carried by req_cmd
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_NEXT  = 1'b1;

   // region codes; the spare code acts as idle
   localparam logic [1:0] REGION_IDLE  = 2'd0;
   localparam logic [1:0] REGION_ONE   = 2'd1;
   localparam logic [1:0] REGION_TWO   = 2'd2;

   typedef enum logic [1:0] {
      ALU_ADD = 2'd0,
      ALU_SUB = 2'd1,
      ALU_MUL = 2'd2
   } alu_op_type;

   typedef struct packed {
      logic neg;
      logic zero;
   } alu_flags_type;

endpackage

>>> sv/epg_alu.sv
`timescale 1ns / 1ps
// epg_alu: shared arithmetic unit (add, subtract, unsigned multiply).
// Depends on epg_pkg. Result is registered by whichever register the sequencer targets.
module epg_alu import epg_pkg::*; #(
   parameter int RADIUS_BITS = 11,
   parameter int ACC_BITS    = 40
) (
   input  alu_op_type             op,
   input  logic [ACC_BITS-1:0]    opd_a,
   input  logic [ACC_BITS-1:0]    opd_b,
   output logic [ACC_BITS-1:0]    result,
   output alu_flags_type          flags
);

   localparam int SQ_BITS   = 2 * RADIUS_BITS + 1;
   localparam int PROD_BITS = 3 * RADIUS_BITS + 1;

   logic [PROD_BITS-1:0] prod;

   // multiply takes a squared term (or a radius) times a radius
   assign prod = opd_a[SQ_BITS-1:0] * opd_b[RADIUS_BITS-1:0];

   always_comb begin
      case (op)
         ALU_ADD: result = opd_a + opd_b;
         ALU_SUB: result = opd_a - opd_b;
         ALU_MUL: result = {{(ACC_BITS-PROD_BITS){1'b0}}, prod};
         default: result = '0;
      endcase
   end

   assign flags.neg  = result[ACC_BITS-1];
   assign flags.zero = (result == '0);

endmodule

>>> sv/ellipse_point_generator.sv
`timescale 1ns / 1ps
// ellipse_point_generator: first-quadrant midpoint ellipse rasterizer.
// Channels: req_ (cmd, radii) in, rsp_ (one result item per request item) out,
// both valid/stall; an item moves on a clock edge with valid high and stall low.
// A start item (cmd 0) loads the radii and returns an all-zero item, or an item
// with bad_radius set if either radius is zero (state is then left alone).
// Each next item (cmd 1) returns the current point, then advances it; the final
// point of region 2 carries last_point. A next item while idle returns zeros.
// All arithmetic runs through one shared add/sub/multiply unit under a
// sequencer, one operation per cycle, so req_stall is high while an item works:
//   start: square both radii, form the x stop value, then the first change term,
//   next : step the primary axis, test, step the secondary axis when due, compare,
//          set up region 2 on a change; zero radius or idle next: straight to the result.
// The result sits in an output register; while rsp_stall holds it, the block
// finishes the following item and waits with it until the register frees.
// Synchronous reset returns to idle with no result pending.
// Accumulators are 3*RADIUS_BITS+7 bits signed.
module ellipse_point_generator import epg_pkg::*; #(
   parameter int RADIUS_BITS = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_cmd,
   input  logic [RADIUS_BITS-1:0] req_x_radius,
   input  logic [RADIUS_BITS-1:0] req_y_radius,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_point_valid,
   output logic [RADIUS_BITS-1:0] rsp_point_x,
   output logic [RADIUS_BITS-1:0] rsp_point_y,
   output logic                   rsp_last_point,
   output logic                   rsp_bad_radius
);

   localparam int SQ_BITS  = 2 * RADIUS_BITS + 1;
   localparam int ACC_BITS = 3 * RADIUS_BITS + 7;

   typedef enum logic [15:0] {
      ST_IDLE      = 16'h0001,
      ST_MUL_A     = 16'h0002,
      ST_MUL_B     = 16'h0004,
      ST_MUL_STOP  = 16'h0008,
      ST_START_CHG = 16'h0010,
      ST_ADV_STOP  = 16'h0020,
      ST_ADV_ERR   = 16'h0040,
      ST_ADV_CHG   = 16'h0080,
      ST_TEST      = 16'h0100,
      ST_TAKE_STOP = 16'h0200,
      ST_TAKE_ERR  = 16'h0400,
      ST_TAKE_CHG  = 16'h0800,
      ST_CMP       = 16'h1000,
      ST_ENTER_MUL = 16'h2000,
      ST_ENTER_CHG = 16'h4000,
      ST_DONE      = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] region_ff, region_in;
   logic [RADIUS_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [RADIUS_BITS-1:0] rad_a_ff, rad_a_in, rad_b_ff, rad_b_in;
   logic [SQ_BITS-1:0] two_a_sq_ff, two_a_sq_in, two_b_sq_ff, two_b_sq_in;
   logic [ACC_BITS-1:0] x_chg_ff, x_chg_in, y_chg_ff, y_chg_in;
   logic [ACC_BITS-1:0] err_ff, err_in, stop_x_ff, stop_x_in, stop_y_ff, stop_y_in;

   // result waiting to be loaded into the output register
   logic pend_valid_ff, pend_valid_in, pend_last_ff, pend_last_in;
   logic pend_bad_ff, pend_bad_in;
   logic [RADIUS_BITS-1:0] pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_point_valid_ff, rsp_last_ff, rsp_bad_ff;
   logic [RADIUS_BITS-1:0] rsp_x_ff, rsp_y_ff;

   alu_op_type alu_op;
   logic [ACC_BITS-1:0] alu_a, alu_b, alu_res;
   alu_flags_type alu_flags;

   logic accept, rsp_load, in_one, radius_zero;
   logic [ACC_BITS-1:0] two_a_ext, two_b_ext, half_a_ext, half_b_ext;
   logic [ACC_BITS-1:0] rad_a_ext, rad_b_ext;
   logic [ACC_BITS-1:0] p_stop, p_chg, p_sq, s_stop, s_chg, s_sq;

   epg_alu #(
      .RADIUS_BITS (RADIUS_BITS),
      .ACC_BITS    (ACC_BITS)
   ) u_alu (
      .op     (alu_op),
      .opd_a  (alu_a),
      .opd_b  (alu_b),
      .result (alu_res),
      .flags  (alu_flags)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid && !req_stall;
   assign rsp_load    = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign radius_zero = (req_x_radius == '0) || (req_y_radius == '0);
   assign in_one      = (region_ff == REGION_ONE);

   assign two_a_ext  = {{(ACC_BITS-SQ_BITS){1'b0}}, two_a_sq_ff};
   assign two_b_ext  = {{(ACC_BITS-SQ_BITS){1'b0}}, two_b_sq_ff};
   assign half_a_ext = {{(ACC_BITS-SQ_BITS+1){1'b0}}, two_a_sq_ff[SQ_BITS-1:1]};
   assign half_b_ext = {{(ACC_BITS-SQ_BITS+1){1'b0}}, two_b_sq_ff[SQ_BITS-1:1]};
   assign rad_a_ext  = {{(ACC_BITS-RADIUS_BITS){1'b0}}, rad_a_ff};
   assign rad_b_ext  = {{(ACC_BITS-RADIUS_BITS){1'b0}}, rad_b_ff};

   // primary axis always steps: y in region 1, x in region 2
   assign p_stop = in_one ? stop_y_ff : stop_x_ff;
   assign p_chg  = in_one ? y_chg_ff  : x_chg_ff;
   assign p_sq   = in_one ? two_a_ext : two_b_ext;
   assign s_stop = in_one ? stop_x_ff : stop_y_ff;
   assign s_chg  = in_one ? x_chg_ff  : y_chg_ff;
   assign s_sq   = in_one ? two_b_ext : two_a_ext;

   always_comb begin
      state_in      = state_ff;
      region_in     = region_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      rad_a_in      = rad_a_ff;
      rad_b_in      = rad_b_ff;
      two_a_sq_in   = two_a_sq_ff;
      two_b_sq_in   = two_b_sq_ff;
      x_chg_in      = x_chg_ff;
      y_chg_in      = y_chg_ff;
      err_in        = err_ff;
      stop_x_in     = stop_x_ff;
      stop_y_in     = stop_y_ff;
      pend_valid_in = pend_valid_ff;
      pend_last_in  = pend_last_ff;
      pend_bad_in   = pend_bad_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      alu_op        = ALU_ADD;
      alu_a         = '0;
      alu_b         = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_valid_in = 1'b0;
               pend_last_in  = 1'b0;
               pend_bad_in   = 1'b0;
               pend_x_in     = '0;
               pend_y_in     = '0;
               if (req_cmd == CMD_START) begin
                  if (radius_zero) begin
                     pend_bad_in = 1'b1;
                     state_in    = ST_DONE;
                  end else begin
                     rad_a_in = req_x_radius;
                     rad_b_in = req_y_radius;
                     state_in = ST_MUL_A;
                  end
               end else if (region_ff == REGION_ONE || region_ff == REGION_TWO) begin
                  pend_valid_in = 1'b1;
                  pend_x_in     = cur_x_ff;
                  pend_y_in     = cur_y_ff;
                  state_in      = ST_ADV_STOP;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MUL_A: begin
            alu_op      = ALU_MUL;
            alu_a       = rad_a_ext;
            alu_b       = rad_a_ext;
            two_a_sq_in = {alu_res[SQ_BITS-2:0], 1'b0};
            state_in    = ST_MUL_B;
         end
         ST_MUL_B: begin
            alu_op      = ALU_MUL;
            alu_a       = rad_b_ext;
            alu_b       = rad_b_ext;
            two_b_sq_in = {alu_res[SQ_BITS-2:0], 1'b0};
            state_in    = ST_MUL_STOP;
         end
         ST_MUL_STOP: begin
            alu_op    = ALU_MUL;
            alu_a     = two_b_ext;
            alu_b     = rad_a_ext;
            stop_x_in = alu_res;
            state_in  = ST_START_CHG;
         end
         ST_START_CHG: begin
            // b^2 (1 - 2a) = b^2 - 2 b^2 a
            alu_op    = ALU_SUB;
            alu_a     = half_b_ext;
            alu_b     = stop_x_ff;
            x_chg_in  = alu_res;
            y_chg_in  = half_a_ext;
            err_in    = '0;
            stop_y_in = '0;
            cur_x_in  = rad_a_ff;
            cur_y_in  = '0;
            region_in = REGION_ONE;
            state_in  = ST_DONE;
         end
         ST_ADV_STOP: begin
            alu_op = ALU_ADD;
            alu_a  = p_stop;
            alu_b  = p_sq;
            if (in_one) begin
               stop_y_in = alu_res;
               cur_y_in  = cur_y_ff + 1'b1;
            end else begin
               stop_x_in = alu_res;
               cur_x_in  = cur_x_ff + 1'b1;
            end
            state_in = ST_ADV_ERR;
         end
         ST_ADV_ERR: begin
            alu_op   = ALU_ADD;
            alu_a    = err_ff;
            alu_b    = p_chg;
            err_in   = alu_res;
            state_in = ST_ADV_CHG;
         end
         ST_ADV_CHG: begin
            alu_op = ALU_ADD;
            alu_a  = p_chg;
            alu_b  = p_sq;
            if (in_one) begin
               y_chg_in = alu_res;
            end else begin
               x_chg_in = alu_res;
            end
            state_in = ST_TEST;
         end
         ST_TEST: begin
            // secondary axis steps when 2*err + change is positive
            alu_op = ALU_ADD;
            alu_a  = {err_ff[ACC_BITS-2:0], 1'b0};
            alu_b  = s_chg;
            if (!alu_flags.neg && !alu_flags.zero) begin
               state_in = ST_TAKE_STOP;
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_TAKE_STOP: begin
            alu_op = ALU_SUB;
            alu_a  = s_stop;
            alu_b  = s_sq;
            if (in_one) begin
               stop_x_in = alu_res;
               cur_x_in  = cur_x_ff - 1'b1;
            end else begin
               stop_y_in = alu_res;
               cur_y_in  = cur_y_ff - 1'b1;
            end
            state_in = ST_TAKE_ERR;
         end
         ST_TAKE_ERR: begin
            alu_op   = ALU_ADD;
            alu_a    = err_ff;
            alu_b    = s_chg;
            err_in   = alu_res;
            state_in = ST_TAKE_CHG;
         end
         ST_TAKE_CHG: begin
            alu_op = ALU_ADD;
            alu_a  = s_chg;
            alu_b  = s_sq;
            if (in_one) begin
               x_chg_in = alu_res;
            end else begin
               y_chg_in = alu_res;
            end
            state_in = ST_CMP;
         end
         ST_CMP: begin
            alu_op   = ALU_SUB;
            alu_a    = stop_x_ff;
            alu_b    = stop_y_ff;
            state_in = ST_DONE;
            if (in_one) begin
               if (alu_flags.neg) begin
                  state_in = ST_ENTER_MUL;
               end
            end else if (!alu_flags.neg && !alu_flags.zero) begin
               pend_last_in = 1'b1;
               region_in    = REGION_IDLE;
            end
         end
         ST_ENTER_MUL: begin
            alu_op    = ALU_MUL;
            alu_a     = two_a_ext;
            alu_b     = rad_b_ext;
            stop_y_in = alu_res;
            state_in  = ST_ENTER_CHG;
         end
         ST_ENTER_CHG: begin
            alu_op    = ALU_SUB;
            alu_a     = half_a_ext;
            alu_b     = stop_y_ff;
            y_chg_in  = alu_res;
            x_chg_in  = half_b_ext;
            err_in    = '0;
            stop_x_in = '0;
            cur_x_in  = '0;
            cur_y_in  = rad_b_ff;
            region_in = REGION_TWO;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         region_ff    <= REGION_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         region_ff    <= region_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      rad_a_ff      <= rad_a_in;
      rad_b_ff      <= rad_b_in;
      two_a_sq_ff   <= two_a_sq_in;
      two_b_sq_ff   <= two_b_sq_in;
      x_chg_ff      <= x_chg_in;
      y_chg_ff      <= y_chg_in;
      err_ff        <= err_in;
      stop_x_ff     <= stop_x_in;
      stop_y_ff     <= stop_y_in;
      pend_valid_ff <= pend_valid_in;
      pend_last_ff  <= pend_last_in;
      pend_bad_ff   <= pend_bad_in;
      pend_x_ff     <= pend_x_in;
      pend_y_ff     <= pend_y_in;
      if (rsp_load) begin
         rsp_point_valid_ff <= pend_valid_ff;
         rsp_last_ff        <= pend_last_ff;
         rsp_bad_ff         <= pend_bad_ff;
         rsp_x_ff           <= pend_x_ff;
         rsp_y_ff           <= pend_y_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_valid = rsp_point_valid_ff;
   assign rsp_point_x     = rsp_x_ff;
   assign rsp_point_y     = rsp_y_ff;
   assign rsp_last_point  = rsp_last_ff;
   assign rsp_bad_radius  = rsp_bad_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_last_has_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_point |-> rsp_point_valid && !rsp_bad_radius)
      else $error("last point flagged without a point");

   a_bad_no_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_radius |-> !rsp_point_valid)
      else $error("rejected start carries a point");

   a_last_ends_region: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && pend_last_ff |-> region_ff == REGION_IDLE)
      else $error("last point left a region active");

   a_squares_loaded: assert property (@(posedge clock) disable iff (reset)
      (region_ff == REGION_ONE || region_ff == REGION_TWO)
         |-> (two_a_sq_ff != '0) && (two_b_sq_ff != '0))
      else $error("active region with zero squared radius");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for ellipse_point_generator, with an in-bench
// point predictor and a scoreboard class. Depends on epg_pkg and the RTL only.
module tb_top;
   import epg_pkg::*;

   localparam int RB = 11;
   localparam int QUIET_LIMIT = 1000;
   localparam int TARGET_ITEMS = 400;

   typedef struct packed {
      logic          point_valid;
      logic [RB-1:0] point_x;
      logic [RB-1:0] point_y;
      logic          last_point;
      logic          bad_radius;
   } point_result_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   logic          req_cmd;
   logic [RB-1:0] req_x_radius;
   logic [RB-1:0] req_y_radius;
   logic          rsp_valid;
   logic          rsp_stall;
   logic          rsp_point_valid;
   logic [RB-1:0] rsp_point_x;
   logic [RB-1:0] rsp_point_y;
   logic          rsp_last_point;
   logic          rsp_bad_radius;

   bit calm;         // both sides run without idling while set
   int items_sent;
   int quiet_cycles;

   class point_scoreboard;
      point_result_type expected_points[$];
      int errors;
      int checked;
      logic [1:0] region;
      logic [RB-1:0] cur_x, cur_y, rad_a, rad_b;
      longint two_a_sq, two_b_sq, dx, dy, err, lim_x, lim_y;

      function new();
         errors = 0;
         checked = 0;
         region = REGION_IDLE;
         cur_x = '0;
         cur_y = '0;
         rad_a = '0;
         rad_b = '0;
         two_a_sq = 0;
         two_b_sq = 0;
         dx = 0;
         dy = 0;
         err = 0;
         lim_x = 0;
         lim_y = 0;
      endfunction

      function bit tracing();
         return region == REGION_ONE || region == REGION_TWO;
      endfunction

      function int pending_count();
         return expected_points.size();
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 30) begin
            $display("ERROR: %s", msg);
         end
      endtask

      // advance the rasterizer by one accepted item and queue its result
      function void note_request(logic cmd, logic [RB-1:0] xr, logic [RB-1:0] yr);
         point_result_type r;
         longint a, b;
         r = '0;
         if (cmd == CMD_START) begin
            if (xr == 0 || yr == 0) begin
               r.bad_radius = 1'b1;
            end else begin
               a = longint'(xr);
               b = longint'(yr);
               rad_a = xr;
               rad_b = yr;
               two_a_sq = 2 * a * a;
               two_b_sq = 2 * b * b;
               region = REGION_ONE;
               cur_x = xr;
               cur_y = '0;
               dx = b * b * (1 - 2 * a);
               dy = a * a;
               err = 0;
               lim_x = two_b_sq * a;
               lim_y = 0;
            end
         end else if (region == REGION_ONE) begin
            r.point_valid = 1'b1;
            r.point_x = cur_x;
            r.point_y = cur_y;
            cur_y = cur_y + 1'b1;
            lim_y += two_a_sq;
            err += dy;
            dy += two_a_sq;
            if (2 * err + dx > 0) begin
               cur_x = cur_x - 1'b1;
               lim_x -= two_b_sq;
               err += dx;
               dx += two_b_sq;
            end
            if (lim_x < lim_y) begin
               // switch to the steep part, restarting from the top of the y axis
               a = longint'(rad_a);
               b = longint'(rad_b);
               region = REGION_TWO;
               cur_x = '0;
               cur_y = rad_b;
               dx = b * b;
               dy = a * a * (1 - 2 * b);
               err = 0;
               lim_x = 0;
               lim_y = two_a_sq * b;
            end
         end else if (region == REGION_TWO) begin
            r.point_valid = 1'b1;
            r.point_x = cur_x;
            r.point_y = cur_y;
            cur_x = cur_x + 1'b1;
            lim_x += two_b_sq;
            err += dx;
            dx += two_b_sq;
            if (2 * err + dy > 0) begin
               cur_y = cur_y - 1'b1;
               lim_y -= two_a_sq;
               err += dy;
               dy += two_a_sq;
            end
            if (lim_x > lim_y) begin
               r.last_point = 1'b1;
               region = REGION_IDLE;
            end
         end
         expected_points.push_back(r);
      endfunction

      task check_point(point_result_type got);
         point_result_type want;
         checked++;
         if (expected_points.size() == 0) begin
            report($sformatf("result %0d arrived with nothing expected", checked));
         end else begin
            want = expected_points.pop_front();
            if (got.point_valid !== want.point_valid)
               report($sformatf("result %0d point_valid got %0b expected %0b",
                                checked, got.point_valid, want.point_valid));
            if (got.point_x !== want.point_x)
               report($sformatf("result %0d point_x got %0d expected %0d",
                                checked, got.point_x, want.point_x));
            if (got.point_y !== want.point_y)
               report($sformatf("result %0d point_y got %0d expected %0d",
                                checked, got.point_y, want.point_y));
            if (got.last_point !== want.last_point)
               report($sformatf("result %0d last_point got %0b expected %0b",
                                checked, got.last_point, want.last_point));
            if (got.bad_radius !== want.bad_radius)
               report($sformatf("result %0d bad_radius got %0b expected %0b",
                                checked, got.bad_radius, want.bad_radius));
         end
      endtask
   endclass

   point_scoreboard sb = new();

   ellipse_point_generator #(.RADIUS_BITS(RB)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_x_radius    (req_x_radius),
      .req_y_radius    (req_y_radius),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_point_valid (rsp_point_valid),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_last_point  (rsp_last_point),
      .rsp_bad_radius  (rsp_bad_radius)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(input logic cmd, input logic [RB-1:0] xr,
                            input logic [RB-1:0] yr);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_x_radius <= xr;
      req_y_radius <= yr;
      do @(posedge clock); while (req_stall);
      sb.note_request(cmd, xr, yr);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_next();
      send_item(CMD_NEXT, RB'($urandom_range(0, 2047)), RB'($urandom_range(0, 2047)));
   endtask

   task automatic trace_to_end(input int cap);
      int n;
      n = 0;
      while (sb.tracing() && n < cap) begin
         send_next();
         n++;
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending_count() != 0) @(negedge clock);
   endtask

   // result side
   initial begin
      int n;
      point_result_type got;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = calm ? 0 : $urandom_range(0, 6);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         got.point_valid = rsp_point_valid;
         got.point_x = rsp_point_x;
         got.point_y = rsp_point_y;
         got.last_point = rsp_last_point;
         got.bad_radius = rsp_bad_radius;
         sb.check_point(got);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      int kind;
      int n;
      logic [RB-1:0] xr, yr;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_NEXT;
      req_x_radius = '0;
      req_y_radius = '0;
      calm = 1'b0;
      items_sent = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // directed: idle next, zero radii, tiny full ellipse, extremes, restart
      send_item(CMD_NEXT, 11'd2047, 11'd2047);
      send_item(CMD_START, 11'd0, 11'd2047);
      send_item(CMD_START, 11'd2047, 11'd0);
      send_item(CMD_START, 11'd0, 11'd0);
      send_item(CMD_NEXT, 11'd0, 11'd0);
      send_item(CMD_START, 11'd1, 11'd1);
      trace_to_end(8);
      send_next();
      send_item(CMD_START, 11'd2047, 11'd2047);
      repeat (3) send_next();
      send_item(CMD_START, 11'd2047, 11'd1);
      repeat (2) send_next();
      // restart while the previous ellipse is still running
      send_item(CMD_START, 11'd1, 11'd2047);
      repeat (2) send_next();
      wait_for_drain();

      while (items_sent < TARGET_ITEMS) begin
         if ($urandom_range(0, 3) == 0) calm = !calm;
         if ($urandom_range(0, 9) == 0) wait_for_drain();
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            xr = ($urandom_range(0, 3) == 0) ? RB'($urandom_range(1, 40))
                                              : RB'($urandom_range(1, 12));
            yr = ($urandom_range(0, 3) == 0) ? RB'($urandom_range(1, 40))
                                              : RB'($urandom_range(1, 12));
            send_item(CMD_START, xr, yr);
            trace_to_end(200);
            repeat ($urandom_range(0, 1)) send_next();
         end else if (kind == 6) begin
            send_item(CMD_START, RB'($urandom_range(1, 2047)), RB'($urandom_range(1, 2047)));
            repeat ($urandom_range(0, 6)) send_next();
         end else if (kind == 7) begin
            if ($urandom_range(0, 1))
               send_item(CMD_START, 11'd0, RB'($urandom_range(0, 2047)));
            else
               send_item(CMD_START, RB'($urandom_range(0, 2047)), 11'd0);
         end else if (kind == 8) begin
            send_next();
         end else begin
            // broken sequence: cut short by whatever comes next
            send_item(CMD_START, RB'($urandom_range(1, 24)), RB'($urandom_range(1, 24)));
            n = $urandom_range(0, 5);
            repeat (n) send_next();
         end
      end

      req_valid <= 1'b0;
      while (sb.pending_count() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> ellipse_point_generator.f
sv/epg_pkg.sv
sv/epg_alu.sv
sv/ellipse_point_generator.sv
tb/tb_top.sv
